// ----- rtl/fcpm_pkg.sv -----
package fcpm_pkg;

   // Build-time default for the largest transform length.
   localparam int POINTS_DEFAULT = 64;

   // Fixed-point layout of a spectrum value and its arithmetic.
   localparam int DATA_W    = 56;
   localparam int FRAC_BITS = 8;
   localparam int TW_BITS   = 22;
   localparam int TW_W      = 24;
   localparam int CHUNK_W   = 14;
   localparam int PART_W    = DATA_W + CHUNK_W + 1;
   localparam int ACC_W     = 2 * DATA_W + 2;
   localparam int LOG_W     = 3;
   localparam int INDEX_W   = 6;

   // Transform length code after reset.
   localparam logic [LOG_W-1:0] LOG_POINTS_RESET = 3'd6;

   typedef struct packed {
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [37:0]        product_coef;
      logic [INDEX_W-1:0]        coef_index;
      logic                      last_out;
   } rsp_type;

   // One complex spectrum entry as kept in memory.
   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } spec_entry_type;

   // Control and status between the sequencer and the complex multiplier.
   typedef struct packed {
      logic start;
      logic spec_mode;
   } cmul_ctl_type;

   typedef struct packed {
      logic done;
   } cmul_sts_type;

   // First quarter of a 64-point cosine wave in Q1.22.
   function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] j);
      logic signed [TW_W-1:0] v;
      case (j)
         5'd0:    v = 24'sd4194304;
         5'd1:    v = 24'sd4174107;
         5'd2:    v = 24'sd4113712;
         5'd3:    v = 24'sd4013699;
         5'd4:    v = 24'sd3875032;
         5'd5:    v = 24'sd3699046;
         5'd6:    v = 24'sd3487436;
         5'd7:    v = 24'sd3242241;
         5'd8:    v = 24'sd2965821;
         5'd9:    v = 24'sd2660838;
         5'd10:   v = 24'sd2330230;
         5'd11:   v = 24'sd1977181;
         5'd12:   v = 24'sd1605091;
         5'd13:   v = 24'sd1217542;
         5'd14:   v = 24'sd818268;
         5'd15:   v = 24'sd411114;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

   // Full-period cosine built from the quarter wave by symmetry.
   function automatic logic signed [TW_W-1:0] tw_cos(input logic [5:0] j);
      logic signed [TW_W-1:0] v;
      if (j <= 6'd16) begin
         v = quarter_cos(5'(j));
      end else if (j <= 6'd32) begin
         v = -quarter_cos(5'(6'd32 - j));
      end else if (j <= 6'd48) begin
         v = -quarter_cos(5'(j - 6'd32));
      end else begin
         v = quarter_cos(5'(6'd0 - j));
      end
      return v;
   endfunction

endpackage

// ----- rtl/fcpm_ram.sv -----
module fcpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/fcpm_cmul.sv -----
module fcpm_cmul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcpm_pkg::cmul_ctl_type                ctl,
   input  logic signed [fcpm_pkg::DATA_W-1:0]    p_re,
   input  logic signed [fcpm_pkg::DATA_W-1:0]    p_im,
   input  logic signed [fcpm_pkg::DATA_W-1:0]    q_re,
   input  logic signed [fcpm_pkg::DATA_W-1:0]    q_im,
   output fcpm_pkg::cmul_sts_type                sts,
   output logic signed [fcpm_pkg::DATA_W-1:0]    r_re,
   output logic signed [fcpm_pkg::DATA_W-1:0]    r_im
);

   localparam int DW = fcpm_pkg::DATA_W;
   localparam int AC = fcpm_pkg::ACC_W;
   localparam int PW = fcpm_pkg::PART_W;
   localparam int CK = fcpm_pkg::CHUNK_W;

   // Operand registers, captured on start.
   logic signed [DW-1:0] p_re_ff, p_re_in, p_im_ff, p_im_in;
   logic signed [DW-1:0] q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic                 spec_ff, spec_in;

   // Control state.
   logic [3:0] step_ff, step_in;
   logic       run_ff, run_in;
   logic       pvld_ff, pvld_in;
   logic       plast_ff, plast_in;
   logic       fin_ff, fin_in;
   logic       done_ff, done_in;

   // Partial product stage and accumulators.
   logic signed [PW-1:0] part_ff, part_in;
   logic [1:0]           pshift_ff, pshift_in;
   logic                 pim_ff, pim_in;
   logic                 pneg_ff, pneg_in;
   logic signed [AC-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [DW-1:0] r_re_ff, r_re_in, r_im_ff, r_im_in;

   logic [1:0]           prod_sel;
   logic [1:0]           chunk_sel;
   logic signed [DW-1:0] src;
   logic signed [DW-1:0] mult;
   logic [CK-1:0]        bits;
   logic signed [CK:0]   chunk;
   logic signed [AC-1:0] ext;
   logic signed [AC-1:0] shifted;
   logic signed [AC-1:0] rnd_re;
   logic signed [AC-1:0] rnd_im;

   // Each real product is built from four 14-bit slices of the p operand;
   // the four products feed the real and imaginary accumulators.
   always_comb begin
      prod_sel  = step_ff[3:2];
      chunk_sel = step_ff[1:0];
      src       = prod_sel[0] ? p_im_ff : p_re_ff;
      mult      = (prod_sel[0] ^ prod_sel[1]) ? q_im_ff : q_re_ff;
      bits      = src[32'(chunk_sel) * CK +: CK];
      chunk     = {(chunk_sel == 2'd3) & bits[CK-1], bits};
      part_in   = PW'(mult) * PW'(chunk);
      pshift_in = chunk_sel;
      pim_in    = prod_sel[1];
      pneg_in   = (prod_sel == 2'd1);
   end

   // Align the registered partial product to its slice position.
   always_comb begin
      ext = AC'(part_ff);
      case (pshift_ff)
         2'd0:    shifted = ext;
         2'd1:    shifted = ext <<< CK;
         2'd2:    shifted = ext <<< (2 * CK);
         2'd3:    shifted = ext <<< (3 * CK);
         default: shifted = ext;
      endcase
   end

   // Round to the fraction width of the chosen mode.
   always_comb begin
      if (spec_ff) begin
         rnd_re  = acc_re_ff + (AC'(1) <<< (fcpm_pkg::FRAC_BITS - 1));
         rnd_im  = acc_im_ff + (AC'(1) <<< (fcpm_pkg::FRAC_BITS - 1));
         r_re_in = rnd_re[fcpm_pkg::FRAC_BITS +: DW];
         r_im_in = rnd_im[fcpm_pkg::FRAC_BITS +: DW];
      end else begin
         rnd_re  = acc_re_ff + (AC'(1) <<< (fcpm_pkg::TW_BITS - 1));
         rnd_im  = acc_im_ff + (AC'(1) <<< (fcpm_pkg::TW_BITS - 1));
         r_re_in = rnd_re[fcpm_pkg::TW_BITS +: DW];
         r_im_in = rnd_im[fcpm_pkg::TW_BITS +: DW];
      end
   end

   // Sequencing of the sixteen partial products.
   always_comb begin
      p_re_in   = p_re_ff;
      p_im_in   = p_im_ff;
      q_re_in   = q_re_ff;
      q_im_in   = q_im_ff;
      spec_in   = spec_ff;
      step_in   = step_ff;
      run_in    = run_ff;
      pvld_in   = 1'b0;
      plast_in  = 1'b0;
      fin_in    = plast_ff;
      done_in   = fin_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;

      if (pvld_ff) begin
         if (pim_ff) begin
            acc_im_in = acc_im_ff + shifted;
         end else if (pneg_ff) begin
            acc_re_in = acc_re_ff - shifted;
         end else begin
            acc_re_in = acc_re_ff + shifted;
         end
      end

      if (run_ff) begin
         pvld_in = 1'b1;
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            run_in   = 1'b0;
            plast_in = 1'b1;
         end
      end

      if (ctl.start) begin
         p_re_in   = p_re;
         p_im_in   = p_im;
         q_re_in   = q_re;
         q_im_in   = q_im;
         spec_in   = ctl.spec_mode;
         step_in   = 4'd0;
         run_in    = 1'b1;
         acc_re_in = '0;
         acc_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         pvld_ff  <= 1'b0;
         plast_ff <= 1'b0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= 4'd0;
      end else begin
         run_ff   <= run_in;
         pvld_ff  <= pvld_in;
         plast_ff <= plast_in;
         fin_ff   <= fin_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      p_re_ff   <= p_re_in;
      p_im_ff   <= p_im_in;
      q_re_ff   <= q_re_in;
      q_im_ff   <= q_im_in;
      spec_ff   <= spec_in;
      part_ff   <= part_in;
      pshift_ff <= pshift_in;
      pim_ff    <= pim_in;
      pneg_ff   <= pneg_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      if (fin_ff) begin
         r_re_ff <= r_re_in;
         r_im_ff <= r_im_in;
      end
   end

   assign sts.done = done_ff;
   assign r_re     = r_re_ff;
   assign r_im     = r_im_ff;

endmodule

// ----- rtl/fft_cyclic_polynomial_multiply.sv -----
// Cyclic polynomial multiplier on a radix-2 fixed-point FFT. Coefficient pairs
// are taken one per cycle (start high, busy low), lowest power first; the pair
// with last set starts the multiply with n = 2^log_points points, clamped to
// 2..POINTS. Busy then stays high while the block bit-reverses and transforms
// both vectors, forms the pointwise spectral products, runs the inverse
// transform and emits the n product coefficients, each on rsp_valid for a
// single cycle. The receiver cannot stall, so it must take every result as
// shown. Every butterfly and every spectral product goes through one shared
// complex multiplier that builds each product from sixteen 56x15-bit partial
// products. A run ends with a clearing pass over all POINTS entries of the
// spectrum memories; the same clearing pass runs after reset. log_points may
// be written only while busy is low.
module fft_cyclic_polynomial_multiply #(
   parameter int POINTS = fcpm_pkg::POINTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  fcpm_pkg::req_type               req_data,
   output logic                            busy,
   output logic                            rsp_valid,
   output fcpm_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [fcpm_pkg::LOG_W-1:0]      csr_wdata
);

   localparam int AW      = $clog2(POINTS);
   localparam int NW      = AW + 1;
   localparam int CW      = $clog2(POINTS + 1);
   localparam int LOG_MAX = $clog2(POINTS + 1) - 1;
   localparam int DW      = fcpm_pkg::DATA_W;
   localparam int EW      = $bits(fcpm_pkg::spec_entry_type);

   // Sequencer states.
   localparam logic [4:0] ST_CLEAR   = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_SW_RA   = 5'd2;
   localparam logic [4:0] ST_SW_RB   = 5'd3;
   localparam logic [4:0] ST_SW_WA   = 5'd4;
   localparam logic [4:0] ST_SW_WB   = 5'd5;
   localparam logic [4:0] ST_BF_RA   = 5'd6;
   localparam logic [4:0] ST_BF_RB   = 5'd7;
   localparam logic [4:0] ST_BF_RC   = 5'd8;
   localparam logic [4:0] ST_BF_MUL  = 5'd9;
   localparam logic [4:0] ST_BF_WA   = 5'd10;
   localparam logic [4:0] ST_BF_WB   = 5'd11;
   localparam logic [4:0] ST_MP_RA   = 5'd12;
   localparam logic [4:0] ST_MP_RB   = 5'd13;
   localparam logic [4:0] ST_MP_MUL  = 5'd14;
   localparam logic [4:0] ST_MP_W    = 5'd15;
   localparam logic [4:0] ST_OUT_RA  = 5'd16;
   localparam logic [4:0] ST_OUT_RB  = 5'd17;

   // Which transform is running.
   localparam logic [1:0] PH_FWD_A = 2'd0;
   localparam logic [1:0] PH_FWD_B = 2'd1;
   localparam logic [1:0] PH_INV   = 2'd2;

   logic [4:0]                     state_ff, state_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [2:0]                     stage_ff, stage_in;
   logic [CW-1:0]                  load_count_ff, load_count_in;
   logic [fcpm_pkg::LOG_W-1:0]     log_points_ff, log_points_in;
   fcpm_pkg::spec_entry_type       t0_ff, t0_in;
   fcpm_pkg::spec_entry_type       u_ff, u_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fcpm_pkg::rsp_type              rsp_ff, rsp_in;

   // Memory ports.
   logic                           we_a, we_b;
   logic [AW-1:0]                  wr_addr, rd_addr;
   fcpm_pkg::spec_entry_type       wr_data_a, wr_data_b;
   fcpm_pkg::spec_entry_type       rd_a, rd_b, rd_sel;

   // Complex multiplier connection.
   fcpm_pkg::cmul_ctl_type         cm_ctl;
   fcpm_pkg::cmul_sts_type         cm_sts;
   logic signed [DW-1:0]           cm_p_re, cm_p_im, cm_q_re, cm_q_im;
   logic signed [DW-1:0]           cm_r_re, cm_r_im;

   // Address generation.
   logic [2:0]                     eff_lg;
   logic [NW-1:0]                  n_w;
   logic [AW-1:0]                  last_idx, last_bf;
   logic [AW-1:0]                  rev_full, swap_r;
   logic [AW-1:0]                  half, mask, bf_lo, bf_hi;
   logic [5:0]                     tw_idx;
   logic signed [fcpm_pkg::TW_W-1:0] w_re, w_im_raw, w_im;

   // Butterfly results.
   fcpm_pkg::spec_entry_type       bf_out_lo, bf_out_hi;
   logic signed [DW+1:0]           s_re, s_im, d_re, d_im;
   logic signed [DW:0]             emit_sum;

   fcpm_ram #(.WIDTH(EW), .DEPTH(POINTS)) u_mem_a (
      .clock (clock),
      .we    (we_a),
      .waddr (wr_addr),
      .wdata (wr_data_a),
      .raddr (rd_addr),
      .rdata (rd_a)
   );

   fcpm_ram #(.WIDTH(EW), .DEPTH(POINTS)) u_mem_b (
      .clock (clock),
      .we    (we_b),
      .waddr (wr_addr),
      .wdata (wr_data_b),
      .raddr (rd_addr),
      .rdata (rd_b)
   );

   fcpm_cmul u_cmul (
      .clock (clock),
      .reset (reset),
      .ctl   (cm_ctl),
      .p_re  (cm_p_re),
      .p_im  (cm_p_im),
      .q_re  (cm_q_re),
      .q_im  (cm_q_im),
      .sts   (cm_sts),
      .r_re  (cm_r_re),
      .r_im  (cm_r_im)
   );

   // Effective length, clamped to the built size.
   always_comb begin
      if (log_points_ff < 3'd1) begin
         eff_lg = 3'd1;
      end else if (log_points_ff > 3'(LOG_MAX)) begin
         eff_lg = 3'(LOG_MAX);
      end else begin
         eff_lg = log_points_ff;
      end
      n_w      = NW'(1) << eff_lg;
      last_idx = AW'(n_w - NW'(1));
      last_bf  = last_idx >> 1;
   end

   // Bit-reversed partner of the swap index.
   always_comb begin
      for (int b = 0; b < AW; b++) begin
         rev_full[b] = idx_ff[AW-1-b];
      end
      swap_r = rev_full >> (3'(AW) - eff_lg);
   end

   // Butterfly addresses and twiddle for the current stage.
   always_comb begin
      half     = AW'(1) << (stage_ff - 3'd1);
      mask     = half - AW'(1);
      bf_lo    = ((idx_ff >> (stage_ff - 3'd1)) << stage_ff) | (idx_ff & mask);
      bf_hi    = bf_lo | half;
      tw_idx   = 6'(idx_ff & mask) << (3'd6 - stage_ff);
      w_re     = fcpm_pkg::tw_cos(tw_idx);
      w_im_raw = fcpm_pkg::tw_cos(tw_idx + 6'd48);
      w_im     = (phase_ff == PH_INV) ? -w_im_raw : w_im_raw;
   end

   assign rd_sel = (phase_ff == PH_FWD_B) ? rd_b : rd_a;

   // Forward butterflies add and subtract; inverse ones also halve.
   always_comb begin
      s_re = (DW+2)'(u_ff.re) + (DW+2)'(cm_r_re);
      s_im = (DW+2)'(u_ff.im) + (DW+2)'(cm_r_im);
      d_re = (DW+2)'(u_ff.re) - (DW+2)'(cm_r_re);
      d_im = (DW+2)'(u_ff.im) - (DW+2)'(cm_r_im);
      if (phase_ff == PH_INV) begin
         s_re = s_re + (DW+2)'(1);
         s_im = s_im + (DW+2)'(1);
         d_re = d_re + (DW+2)'(1);
         d_im = d_im + (DW+2)'(1);
         bf_out_lo.re = s_re[DW:1];
         bf_out_lo.im = s_im[DW:1];
         bf_out_hi.re = d_re[DW:1];
         bf_out_hi.im = d_im[DW:1];
      end else begin
         bf_out_lo.re = s_re[DW-1:0];
         bf_out_lo.im = s_im[DW-1:0];
         bf_out_hi.re = d_re[DW-1:0];
         bf_out_hi.im = d_im[DW-1:0];
      end
   end

   assign emit_sum = (DW+1)'(rd_a.re) + (DW+1)'(128);

   // Main sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      stage_in      = stage_ff;
      load_count_in = load_count_ff;
      log_points_in = log_points_ff;
      t0_in         = t0_ff;
      u_in          = u_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      we_a          = 1'b0;
      we_b          = 1'b0;
      wr_addr       = idx_ff;
      wr_data_a     = '0;
      wr_data_b     = '0;
      rd_addr       = idx_ff;

      cm_ctl.start     = 1'b0;
      cm_ctl.spec_mode = 1'b0;
      cm_p_re = DW'(w_re);
      cm_p_im = DW'(w_im);
      cm_q_re = rd_sel.re;
      cm_q_im = rd_sel.im;

      if (csr_we) begin
         log_points_in = csr_wdata;
      end

      case (state_ff)
         ST_CLEAR: begin
            we_a = 1'b1;
            we_b = 1'b1;
            if (idx_ff == AW'(POINTS - 1)) begin
               state_in      = ST_IDLE;
               idx_in        = '0;
               load_count_in = '0;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               // Store the pair while the vector still has room.
               if (NW'(load_count_ff) < n_w) begin
                  we_a         = 1'b1;
                  we_b         = 1'b1;
                  wr_addr      = load_count_ff[AW-1:0];
                  wr_data_a.re = {{(DW-24){req_data.coef_a[15]}}, req_data.coef_a, 8'd0};
                  wr_data_b.re = {{(DW-24){req_data.coef_b[15]}}, req_data.coef_b, 8'd0};
                  load_count_in = load_count_ff + CW'(1);
               end
               if (req_data.last) begin
                  state_in = ST_SW_RA;
                  phase_in = PH_FWD_A;
                  idx_in   = '0;
               end
            end
         end

         ST_SW_RA: begin
            if (swap_r > idx_ff) begin
               state_in = ST_SW_RB;
            end else if (idx_ff == last_idx) begin
               state_in = ST_BF_RA;
               idx_in   = '0;
               stage_in = 3'd1;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         ST_SW_RB: begin
            rd_addr  = swap_r;
            t0_in    = rd_sel;
            state_in = ST_SW_WA;
         end

         ST_SW_WA: begin
            we_a      = (phase_ff != PH_FWD_B);
            we_b      = (phase_ff == PH_FWD_B);
            wr_data_a = rd_sel;
            wr_data_b = rd_sel;
            state_in  = ST_SW_WB;
         end

         ST_SW_WB: begin
            we_a      = (phase_ff != PH_FWD_B);
            we_b      = (phase_ff == PH_FWD_B);
            wr_addr   = swap_r;
            wr_data_a = t0_ff;
            wr_data_b = t0_ff;
            if (idx_ff == last_idx) begin
               state_in = ST_BF_RA;
               idx_in   = '0;
               stage_in = 3'd1;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SW_RA;
            end
         end

         ST_BF_RA: begin
            rd_addr  = bf_hi;
            state_in = ST_BF_RB;
         end

         ST_BF_RB: begin
            // Upper input is on the read port: start the twiddle product.
            rd_addr      = bf_lo;
            cm_ctl.start = 1'b1;
            state_in     = ST_BF_RC;
         end

         ST_BF_RC: begin
            u_in     = rd_sel;
            state_in = ST_BF_MUL;
         end

         ST_BF_MUL: begin
            if (cm_sts.done) begin
               state_in = ST_BF_WA;
            end
         end

         ST_BF_WA: begin
            we_a      = (phase_ff != PH_FWD_B);
            we_b      = (phase_ff == PH_FWD_B);
            wr_addr   = bf_lo;
            wr_data_a = bf_out_lo;
            wr_data_b = bf_out_lo;
            state_in  = ST_BF_WB;
         end

         ST_BF_WB: begin
            we_a      = (phase_ff != PH_FWD_B);
            we_b      = (phase_ff == PH_FWD_B);
            wr_addr   = bf_hi;
            wr_data_a = bf_out_hi;
            wr_data_b = bf_out_hi;
            state_in  = ST_BF_RA;
            if (idx_ff == last_bf) begin
               idx_in = '0;
               if (stage_ff == eff_lg) begin
                  // Transform done: move on to the next phase.
                  case (phase_ff)
                     PH_FWD_A: begin
                        phase_in = PH_FWD_B;
                        state_in = ST_SW_RA;
                     end
                     PH_FWD_B: begin
                        state_in = ST_MP_RA;
                     end
                     default: begin
                        state_in = ST_OUT_RA;
                     end
                  endcase
               end else begin
                  stage_in = stage_ff + 3'd1;
               end
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         ST_MP_RA: begin
            state_in = ST_MP_RB;
         end

         ST_MP_RB: begin
            cm_ctl.start     = 1'b1;
            cm_ctl.spec_mode = 1'b1;
            cm_p_re          = rd_a.re;
            cm_p_im          = rd_a.im;
            cm_q_re          = rd_b.re;
            cm_q_im          = rd_b.im;
            state_in         = ST_MP_MUL;
         end

         ST_MP_MUL: begin
            if (cm_sts.done) begin
               state_in = ST_MP_W;
            end
         end

         ST_MP_W: begin
            we_a         = 1'b1;
            wr_data_a.re = cm_r_re;
            wr_data_a.im = cm_r_im;
            if (idx_ff == last_idx) begin
               phase_in = PH_INV;
               state_in = ST_SW_RA;
               idx_in   = '0;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_MP_RA;
            end
         end

         ST_OUT_RA: begin
            state_in = ST_OUT_RB;
         end

         ST_OUT_RB: begin
            rsp_valid_in        = 1'b1;
            rsp_in.product_coef = emit_sum[45:8];
            rsp_in.coef_index   = fcpm_pkg::INDEX_W'(idx_ff);
            rsp_in.last_out     = (idx_ff == last_idx);
            if (idx_ff == last_idx) begin
               state_in = ST_CLEAR;
               idx_in   = '0;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_OUT_RA;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         phase_ff      <= PH_FWD_A;
         idx_ff        <= '0;
         stage_ff      <= 3'd1;
         load_count_ff <= '0;
         log_points_ff <= fcpm_pkg::LOG_POINTS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         stage_ff      <= stage_in;
         load_count_ff <= load_count_in;
         log_points_ff <= log_points_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff  <= t0_in;
      u_ff   <= u_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result transfer only follows an output read.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_OUT_RB))
      else $error("result strobe outside the output phase");

   // The final coefficient of a run hands over to the clearing pass.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_out |-> state_ff == ST_CLEAR)
      else $error("run did not end in the clearing pass");

   // The multiplier only finishes while the sequencer waits for it.
   a_cmul_done: assert property (@(posedge clock) disable iff (reset)
      cm_sts.done |-> (state_ff == ST_BF_MUL || state_ff == ST_MP_MUL))
      else $error("multiplier finished while not awaited");

   // The load counter never passes the built size.
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CW'(POINTS))
      else $error("load counter beyond memory depth");

endmodule
